// ----- hw/rtl/pcsa_pkg.sv -----
`timescale 1ns / 1ps

package pcsa_pkg;

  // Fixed-point formats.
  localparam int ANGLE_FRAC_BITS = 24;
  localparam int COEF_FRAC_BITS  = 30;
  localparam int FB = ANGLE_FRAC_BITS;
  localparam int CB = COEF_FRAC_BITS;

  // Port widths.
  localparam int ANGLE_W = 32;
  localparam int VALUE_W = 22;

  // Request codes.
  localparam logic OP_COS = 1'b0;
  localparam logic OP_SIN = 1'b1;

  // Pi in Q3.61; the angle constants are rounded from it.
  localparam logic [63:0] PI_Q61    = 64'h6487ED5110B4611A;
  localparam logic [63:0] K_PI      = (PI_Q61 + (64'd1 << (60 - FB))) >> (61 - FB);
  localparam logic [63:0] K_TWO_PI  = (PI_Q61 + (64'd1 << (59 - FB))) >> (60 - FB);
  localparam logic [63:0] K_HALF_PI = (PI_Q61 + (64'd1 << (61 - FB))) >> (62 - FB);
  localparam logic [63:0] K_PI6  = ((PI_Q61 / 64'd3) + (64'd1 << (61 - FB))) >> (62 - FB);
  localparam logic [63:0] K_PI12 = ((PI_Q61 / 64'd3) + (64'd1 << (62 - FB))) >> (63 - FB);

  // Polynomial coefficients in Q.CB.
  localparam logic [63:0] C_ONE     = 64'd1 << CB;
  localparam logic [63:0] C_HALF    = 64'd1 << (CB - 1);
  localparam logic [63:0] C_QUARTER = 64'd1 << (CB - 2);
  localparam logic [63:0] C_866     = ((64'd866 << CB) + 64'd500) / 64'd1000;
  localparam logic [63:0] C_433     = ((64'd433 << CB) + 64'd500) / 64'd1000;

  // Range reduction widths and constants.
  localparam int M_W  = $clog2(K_TWO_PI + 64'd1);
  localparam int PI_W = $clog2(K_PI + 64'd1);
  localparam int X_W  = ANGLE_W + 2;
  localparam int U_W  = X_W + 1;
  localparam logic [63:0] OFF_K  = ((64'd1 << (X_W - 1)) + K_TWO_PI - 64'd1) / K_TWO_PI;
  localparam logic [63:0] OFFSET = OFF_K * K_TWO_PI;
  localparam int RCP_SHIFT = 24;
  localparam logic [63:0] RCP = (64'd1 << (FB + RCP_SHIFT)) / K_TWO_PI;
  localparam int RCP_W = $clog2(RCP + 64'd1);
  localparam int UH_W  = U_W - FB;
  localparam int Q_W   = U_W - FB - 2;

  // Polynomial widths.
  localparam int A_W  = FB + 1;
  localparam int A2_W = A_W;
  localparam int C_W  = CB + 2;
  localparam int V_W  = CB + FB + 3;

  // Output scaling widths.
  localparam int MAG_W   = V_W - 1;
  localparam int HI_W    = MAG_W - 32;
  localparam int MIL_W   = 20;
  localparam int SUM_W   = HI_W + MIL_W + 1;
  localparam int QS      = CB + FB - 32;
  localparam int Q_OUT_W = 21;
  localparam logic [MIL_W-1:0] MILLION = MIL_W'(1000000);
  localparam int OUT_LIMIT = 1100000;
  localparam logic signed [VALUE_W-1:0] VALUE_HI = VALUE_W'(OUT_LIMIT);
  localparam logic signed [VALUE_W-1:0] VALUE_LO = -VALUE_HI;

  // Pipeline depth.
  localparam int RED_STAGES = 6;
  localparam int NS = 16;

  // Segment index.
  typedef logic [2:0] seg_t;
  localparam int SEG_MAX = 6;
  localparam seg_t SEG_MID = 3'd3;

  // Reduced angle handed from range reduction to the polynomial stages.
  typedef struct packed {
    logic            flip;
    logic [PI_W-1:0] r;
  } red_t;

  // Lower edge of segment j: j*pi/6 - pi/12.
  function automatic logic [PI_W-1:0] seg_thresh(input seg_t j);
    return PI_W'((64'(j) * K_PI6) - K_PI12);
  endfunction

  // Center of segment k: k*pi/6.
  function automatic logic [PI_W-1:0] seg_start(input seg_t k);
    return PI_W'(64'(k) * K_PI6);
  endfunction

  // Coefficient of the offset a.
  function automatic logic signed [C_W-1:0] coef_lin(input seg_t k);
    logic signed [C_W-1:0] half_c;
    logic signed [C_W-1:0] c866;
    half_c = C_W'(C_HALF);
    c866   = C_W'(C_866);
    case (k)
      3'd1:    return -half_c;
      3'd2:    return -c866;
      3'd4:    return -c866;
      3'd5:    return -half_c;
      default: return '0;
    endcase
  endfunction

  // Coefficient of a squared.
  function automatic logic signed [C_W-1:0] coef_sq(input seg_t k);
    logic signed [C_W-1:0] half_c;
    logic signed [C_W-1:0] quart_c;
    logic signed [C_W-1:0] c433;
    half_c  = C_W'(C_HALF);
    quart_c = C_W'(C_QUARTER);
    c433    = C_W'(C_433);
    case (k)
      3'd0:    return -half_c;
      3'd1:    return -c433;
      3'd2:    return -quart_c;
      3'd3:    return '0;
      3'd4:    return quart_c;
      3'd5:    return c433;
      default: return half_c;
    endcase
  endfunction

  // Constant term of each segment in Q.(CB+FB).
  function automatic logic signed [V_W-1:0] seg_base(input seg_t k);
    logic signed [V_W-1:0] one_v;
    logic signed [V_W-1:0] half_v;
    logic signed [V_W-1:0] c866_v;
    one_v  = V_W'(C_ONE) << FB;
    half_v = V_W'(C_HALF) << FB;
    c866_v = V_W'(C_866) << FB;
    case (k)
      3'd0:    return one_v;
      3'd1:    return c866_v;
      3'd2:    return half_v;
      3'd4:    return -half_v;
      3'd5:    return -c866_v;
      3'd6:    return -one_v;
      default: return '0;
    endcase
  endfunction

endpackage

// ----- hw/rtl/pcsa_reduce.sv -----
`timescale 1ns / 1ps

module pcsa_reduce (
  input  logic                                  clk,
  input  logic [pcsa_pkg::RED_STAGES-1:0]       en,
  input  logic signed [pcsa_pkg::ANGLE_W-1:0]   in_angle,
  input  logic                                  in_opcode,
  output pcsa_pkg::red_t                        red
);

  logic signed [pcsa_pkg::X_W-1:0] ang_x;
  logic signed [pcsa_pkg::X_W-1:0] half_x;
  logic signed [pcsa_pkg::X_W-1:0] x_s;
  logic [pcsa_pkg::U_W-1:0] u_nxt;
  logic [pcsa_pkg::U_W-1:0] u0_r;
  logic [pcsa_pkg::U_W-1:0] u1_r;
  logic [pcsa_pkg::U_W-1:0] u2_r;
  logic [pcsa_pkg::UH_W+pcsa_pkg::RCP_W-1:0] qp;
  logic [pcsa_pkg::Q_W-1:0] qe_nxt;
  logic [pcsa_pkg::Q_W-1:0] qe_r;
  logic [pcsa_pkg::Q_W+pcsa_pkg::M_W-1:0] prod_nxt;
  logic [pcsa_pkg::Q_W+pcsa_pkg::M_W-1:0] prod_r;
  logic [pcsa_pkg::U_W-1:0] diff;
  logic [pcsa_pkg::M_W:0] r0_nxt;
  logic [pcsa_pkg::M_W:0] r0_r;
  logic [pcsa_pkg::M_W-1:0] r_nxt;
  logic [pcsa_pkg::M_W-1:0] r_r;
  pcsa_pkg::red_t red_nxt;
  pcsa_pkg::red_t red_r;

  // Sine maps to cosine of pi/2 minus the angle; an offset of whole turns
  // makes the value non-negative without changing it modulo 2*pi.
  always_comb begin
    ang_x  = pcsa_pkg::X_W'(in_angle);
    half_x = pcsa_pkg::X_W'(pcsa_pkg::K_HALF_PI);
    x_s    = (in_opcode == pcsa_pkg::OP_SIN) ? half_x - ang_x : ang_x;
    u_nxt  = pcsa_pkg::U_W'(x_s) + pcsa_pkg::U_W'(pcsa_pkg::OFFSET);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      u0_r <= u_nxt;
    end
  end

  // Quotient estimate by reciprocal; it is exact or one short.
  always_comb begin
    qp     = u0_r[pcsa_pkg::U_W-1:pcsa_pkg::FB] * pcsa_pkg::RCP_W'(pcsa_pkg::RCP);
    qe_nxt = pcsa_pkg::Q_W'(qp >> pcsa_pkg::RCP_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      qe_r <= qe_nxt;
      u1_r <= u0_r;
    end
  end

  // Whole turns to remove.
  assign prod_nxt = qe_r * pcsa_pkg::M_W'(pcsa_pkg::K_TWO_PI);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      prod_r <= prod_nxt;
      u2_r   <= u1_r;
    end
  end

  // Remainder before correction lies below twice 2*pi.
  always_comb begin
    diff   = u2_r - prod_r[pcsa_pkg::U_W-1:0];
    r0_nxt = diff[pcsa_pkg::M_W:0];
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      r0_r <= r0_nxt;
    end
  end

  // One conditional subtract finishes the reduction into [0, 2*pi).
  always_comb begin
    if (r0_r >= (pcsa_pkg::M_W + 1)'(pcsa_pkg::K_TWO_PI)) begin
      r_nxt = pcsa_pkg::M_W'(r0_r - (pcsa_pkg::M_W + 1)'(pcsa_pkg::K_TWO_PI));
    end else begin
      r_nxt = r0_r[pcsa_pkg::M_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      r_r <= r_nxt;
    end
  end

  // Fold the upper half turn down and remember to negate the result.
  always_comb begin
    red_nxt.flip = r_r > pcsa_pkg::M_W'(pcsa_pkg::K_PI);
    if (red_nxt.flip) begin
      red_nxt.r = pcsa_pkg::PI_W'(r_r - pcsa_pkg::M_W'(pcsa_pkg::K_PI));
    end else begin
      red_nxt.r = pcsa_pkg::PI_W'(r_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      red_r <= red_nxt;
    end
  end

  assign red = red_r;

endmodule

// ----- hw/rtl/piecewise_cosine_sine_approx.sv -----
`timescale 1ns / 1ps

// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   in_angle (s32, Q8.24 rad), in_opcode (1)
// out      output     out_valid / out_ready out_value (s22, value times 10^6)
//
// Sixteen register stages; a request passes through each of them in order before its result leaves.
// One request enters and one result leaves per cycle when the output is taken.
// Reset clears the stage valid bits only; the data registers are not reset.
// A stage holds only while its successor holds, so bubbles close up under a
// stall and in_ready drops only when every stage carries a request.

module piecewise_cosine_sine_approx (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [pcsa_pkg::ANGLE_W-1:0]   in_angle,
  input  logic                                  in_opcode,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [pcsa_pkg::VALUE_W-1:0]   out_value
);

  localparam int NS = pcsa_pkg::NS;

  logic [NS:0]   en;
  logic [NS-1:0] vld_r;
  logic [NS-1:0] vld_nxt;

  pcsa_pkg::red_t red;

  logic [pcsa_pkg::PI_W-1:0] r2_r6, r2_r7, r2_r8, r2_r9;
  logic flip_r6, flip_r7, flip_r8, flip_r9, flip_r10, flip_r11;
  pcsa_pkg::seg_t k_nxt, k_r, k_r7, k_r8, k_r9;
  logic signed [pcsa_pkg::PI_W:0] a_full;
  logic signed [pcsa_pkg::A_W-1:0] a_r, a_r8;
  logic signed [2*pcsa_pkg::A_W-1:0] sq_nxt, sq_r;
  logic [pcsa_pkg::A2_W-1:0] a2;
  logic signed [pcsa_pkg::V_W-1:0] p1_nxt, p1_r;
  logic signed [pcsa_pkg::V_W:0] p2_full;
  logic signed [pcsa_pkg::V_W-1:0] p2_r;
  logic signed [pcsa_pkg::PI_W:0] mid_d;
  logic signed [pcsa_pkg::V_W-1:0] mid_e;
  logic signed [pcsa_pkg::V_W-1:0] base_nxt, base_r, t_r;
  logic signed [pcsa_pkg::V_W-1:0] v_r;
  logic signed [pcsa_pkg::V_W-1:0] v_abs;
  logic [pcsa_pkg::MAG_W-1:0] mag_r;
  logic neg_r12, neg_r13, neg_r14;
  logic [pcsa_pkg::HI_W+pcsa_pkg::MIL_W-1:0] hp_r;
  logic [32+pcsa_pkg::MIL_W-1:0] lp_r;
  logic [pcsa_pkg::SUM_W-1:0] sum;
  logic [pcsa_pkg::SUM_W-1:0] q_r;
  logic [pcsa_pkg::Q_OUT_W-1:0] sat;
  logic signed [pcsa_pkg::VALUE_W-1:0] value_nxt, value_r;

  // A stage may load when it is empty or its content moves on.
  always_comb begin
    en[NS] = out_ready;
    for (int i = NS - 1; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
    vld_nxt[0] = in_valid;
    for (int i = 1; i < NS; i++) begin
      vld_nxt[i] = vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (en[i]) begin
          vld_r[i] <= vld_nxt[i];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[NS-1];
  assign out_value = value_r;

  // Stages 0 to 5: range reduction into [0, pi] with a sign flag.
  pcsa_reduce u_reduce (
    .clk       (clk),
    .en        (en[pcsa_pkg::RED_STAGES-1:0]),
    .in_angle  (in_angle),
    .in_opcode (in_opcode),
    .red       (red)
  );

  // Nearest multiple of pi/6, found against the fixed segment edges.
  always_comb begin
    k_nxt = '0;
    for (int j = 1; j <= pcsa_pkg::SEG_MAX; j++) begin
      if (red.r >= pcsa_pkg::seg_thresh(3'(j))) begin
        k_nxt = 3'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      k_r     <= k_nxt;
      r2_r6   <= red.r;
      flip_r6 <= red.flip;
    end
  end

  // Offset from the segment center.
  assign a_full = $signed({1'b0, r2_r6}) - $signed({1'b0, pcsa_pkg::seg_start(k_r)});

  always_ff @(posedge clk) begin
    if (en[7]) begin
      a_r     <= a_full[pcsa_pkg::A_W-1:0];
      k_r7    <= k_r;
      r2_r7   <= r2_r6;
      flip_r7 <= flip_r6;
    end
  end

  // Square of the offset.
  assign sq_nxt = a_r * a_r;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      sq_r    <= sq_nxt;
      a_r8    <= a_r;
      k_r8    <= k_r7;
      r2_r8   <= r2_r7;
      flip_r8 <= flip_r7;
    end
  end

  // Linear and square terms, each with its segment coefficient.
  always_comb begin
    a2      = sq_r[pcsa_pkg::FB+pcsa_pkg::A2_W-1:pcsa_pkg::FB];
    p1_nxt  = pcsa_pkg::coef_lin(k_r8) * a_r8;
    p2_full = pcsa_pkg::coef_sq(k_r8) * $signed({1'b0, a2});
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      p1_r    <= p1_nxt;
      p2_r    <= p2_full[pcsa_pkg::V_W-1:0];
      k_r9    <= k_r8;
      r2_r9   <= r2_r8;
      flip_r9 <= flip_r8;
    end
  end

  // The middle segment takes pi/2 minus the reduced angle itself.
  always_comb begin
    mid_d = $signed({1'b0, pcsa_pkg::PI_W'(pcsa_pkg::K_HALF_PI)}) - $signed({1'b0, r2_r9});
    mid_e = pcsa_pkg::V_W'(mid_d);
    if (k_r9 == pcsa_pkg::SEG_MID) begin
      base_nxt = mid_e <<< pcsa_pkg::CB;
    end else begin
      base_nxt = pcsa_pkg::seg_base(k_r9);
    end
  end

  always_ff @(posedge clk) begin
    if (en[10]) begin
      t_r      <= p1_r + p2_r;
      base_r   <= base_nxt;
      flip_r10 <= flip_r9;
    end
  end

  always_ff @(posedge clk) begin
    if (en[11]) begin
      v_r      <= base_r + t_r;
      flip_r11 <= flip_r10;
    end
  end

  // Sign of the result after the half-turn flip, and the magnitude.
  assign v_abs = v_r[pcsa_pkg::V_W-1] ? -v_r : v_r;

  always_ff @(posedge clk) begin
    if (en[12]) begin
      mag_r   <= v_abs[pcsa_pkg::MAG_W-1:0];
      neg_r12 <= flip_r11 ? (!v_r[pcsa_pkg::V_W-1] && (v_r != '0)) : v_r[pcsa_pkg::V_W-1];
    end
  end

  // Scale by one million in two partial products.
  always_ff @(posedge clk) begin
    if (en[13]) begin
      hp_r    <= mag_r[pcsa_pkg::MAG_W-1:32] * pcsa_pkg::MILLION;
      lp_r    <= mag_r[31:0] * pcsa_pkg::MILLION;
      neg_r13 <= neg_r12;
    end
  end

  // Combine the partial products and drop the fraction.
  assign sum = pcsa_pkg::SUM_W'(hp_r) + pcsa_pkg::SUM_W'(lp_r[32+pcsa_pkg::MIL_W-1:32]);

  always_ff @(posedge clk) begin
    if (en[14]) begin
      q_r     <= sum >> pcsa_pkg::QS;
      neg_r14 <= neg_r13;
    end
  end

  // Saturate and apply the sign.
  always_comb begin
    if (q_r > pcsa_pkg::SUM_W'(pcsa_pkg::OUT_LIMIT)) begin
      sat = pcsa_pkg::Q_OUT_W'(pcsa_pkg::OUT_LIMIT);
    end else begin
      sat = q_r[pcsa_pkg::Q_OUT_W-1:0];
    end
    value_nxt = neg_r14 ? -$signed({1'b0, sat}) : $signed({1'b0, sat});
  end

  always_ff @(posedge clk) begin
    if (en[15]) begin
      value_r <= value_nxt;
    end
  end

`ifndef SYNTHESIS
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&vld_r))
    else $error("input stalled while the pipeline has an empty stage");

  a_ready_through: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while the output is being taken");

  a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[6] |-> (k_r <= 3'(pcsa_pkg::SEG_MAX)))
    else $error("segment index out of range");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_value >= pcsa_pkg::VALUE_LO && out_value <= pcsa_pkg::VALUE_HI))
    else $error("result outside the saturation limits");
`endif

endmodule
